@@ hdl/rrsg_pkg.sv @@
// ----------------------------------------------------------------------------
// Rounded rectangle span generator package
// Shared constants and the sequencer state type.
// ----------------------------------------------------------------------------
package rrsg_pkg;

    localparam int unsigned MAX_RADIUS  = 255;
    localparam int unsigned RADIUS_W    = 8;
    localparam int unsigned SQ_W        = 2 * RADIUS_W;
    localparam int unsigned ROOT_STEPS  = SQ_W / 2;
    localparam int unsigned STEP_CNT_W  = $clog2(ROOT_STEPS);
    localparam int unsigned ROOT_RES_W  = SQ_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIST,
        ST_SQR,
        ST_SQV,
        ST_ROOT,
        ST_FIN
    } rrsg_state_t;

endpackage

@@ hdl/rounded_rect_span_generator_top.sv @@
// ----------------------------------------------------------------------------
// Rounded rectangle span generator
// Computes the horizontal span of one row of a rounded rectangle, using one
// shared 8x8 multiplier and a digit-by-digit square root step.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Fields
//  in        input      in_valid / in_stall  rect_x .. fill_color
//  out       output     out_valid/ out_stall span_y .. span_color
//
// A corner row passes through the clamp, distance, square and subtract
// states and the 8 square root steps, then the finishing state; a middle
// row or a row outside the rectangle goes from the distance state straight
// to finishing. The square root steps use the shared compare/subtract unit.
// A new item is taken only when the sequencer is idle; the finishing state
// holds while the output register is full and stalled.
// Reset clears the sequencer and the output valid flag.
module rounded_rect_span_generator_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [12:0]  rect_x,
    input  logic signed [12:0]  rect_y,
    input  logic        [11:0]  rect_w,
    input  logic        [11:0]  rect_h,
    input  logic [rrsg_pkg::RADIUS_W-1:0] corner_radius,
    input  logic        [11:0]  row_offset,
    input  logic        [31:0]  fill_color,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [13:0]  span_y,
    output logic signed [13:0]  span_x,
    output logic        [11:0]  span_width,
    output logic                span_valid,
    output logic        [31:0]  span_color
);
    import rrsg_pkg::*;

    rrsg_state_t state_reg, state_next;

    logic signed [12:0]         x_reg, x_next;
    logic signed [12:0]         y_reg, y_next;
    logic [11:0]                w_reg, w_next;
    logic [11:0]                h_reg, h_next;
    logic [11:0]                row_reg, row_next;
    logic [31:0]                color_reg, color_next;
    logic [RADIUS_W-1:0]        r_reg, r_next;
    logic [RADIUS_W-1:0]        vy_reg, vy_next;
    logic                       banded_reg, banded_next;
    logic                       inside_reg, inside_next;
    logic [SQ_W-1:0]            acc_reg, acc_next;
    logic [ROOT_RES_W-1:0]      res_reg, res_next;
    logic [SQ_W-1:0]            bit_reg, bit_next;
    logic [STEP_CNT_W-1:0]      cnt_reg, cnt_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [13:0]         span_y_reg, span_y_next;
    logic signed [13:0]         span_x_reg, span_x_next;
    logic [11:0]                span_width_reg, span_width_next;
    logic                       span_valid_reg, span_valid_next;
    logic [31:0]                span_color_reg, span_color_next;

    logic                       in_accept;
    logic                       out_free;
    logic [RADIUS_W-1:0]        mul_a;
    logic [RADIUS_W-1:0]        mul_b;
    logic [SQ_W-1:0]            product;
    logic [ROOT_RES_W-1:0]      root_trial;
    logic                       root_take;
    logic [RADIUS_W-1:0]        r_clamp;
    logic                       row_inside;
    logic                       row_top;
    logic                       row_bottom;
    logic [11:0]                row_dist;
    logic [RADIUS_W-1:0]        inset;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign span_y     = span_y_reg;
    assign span_x     = span_x_reg;
    assign span_width = span_width_reg;
    assign span_valid = span_valid_reg;
    assign span_color = span_color_reg;

    // Shared multiplier and square root step.
    assign mul_a      = (state_reg == ST_SQR) ? r_reg : vy_reg;
    assign mul_b      = mul_a;
    assign product    = SQ_W'(mul_a) * SQ_W'(mul_b);
    assign root_trial = res_reg + ROOT_RES_W'(bit_reg);
    assign root_take  = ROOT_RES_W'(acc_reg) >= root_trial;

    always_comb
    begin
        r_clamp = r_reg;
        if (32'(r_clamp) > MAX_RADIUS)
        begin
            r_clamp = RADIUS_W'(MAX_RADIUS);
        end
        if (12'(r_clamp) > {1'b0, w_reg[11:1]})
        begin
            r_clamp = RADIUS_W'(w_reg[11:1]);
        end
        if (12'(r_clamp) > {1'b0, h_reg[11:1]})
        begin
            r_clamp = RADIUS_W'(h_reg[11:1]);
        end
    end

    assign row_inside = row_reg < h_reg;
    assign row_top    = row_reg < 12'(r_reg);
    assign row_bottom = row_reg >= (h_reg - 12'(r_reg));
    assign row_dist   = row_top ? row_reg : (h_reg - 12'd1 - row_reg);
    assign inset      = banded_reg ? (r_reg - res_reg[RADIUS_W-1:0]) : '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                if (row_inside && (row_top || row_bottom))
                begin
                    state_next = ST_SQR;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SQR:
            begin
                state_next = ST_SQV;
            end
            ST_SQV:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (cnt_reg == STEP_CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        x_next          = x_reg;
        y_next          = y_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        row_next        = row_reg;
        color_next      = color_reg;
        r_next          = r_reg;
        vy_next         = vy_reg;
        banded_next     = banded_reg;
        inside_next     = inside_reg;
        acc_next        = acc_reg;
        res_next        = res_reg;
        bit_next        = bit_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        span_y_next     = span_y_reg;
        span_x_next     = span_x_reg;
        span_width_next = span_width_reg;
        span_valid_next = span_valid_reg;
        span_color_next = span_color_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    x_next     = rect_x;
                    y_next     = rect_y;
                    w_next     = rect_w;
                    h_next     = rect_h;
                    row_next   = row_offset;
                    color_next = fill_color;
                    r_next     = corner_radius;
                end
            end
            ST_CLAMP:
            begin
                r_next = r_clamp;
            end
            ST_DIST:
            begin
                inside_next = row_inside;
                banded_next = row_inside && (row_top || row_bottom);
                vy_next     = r_reg - RADIUS_W'(1) - row_dist[RADIUS_W-1:0];
            end
            ST_SQR:
            begin
                acc_next = product;
            end
            ST_SQV:
            begin
                acc_next = acc_reg - product;
                res_next = '0;
                bit_next = SQ_W'(1) << (SQ_W - 2);
                cnt_next = '0;
            end
            ST_ROOT:
            begin
                if (root_take)
                begin
                    acc_next = acc_reg - root_trial[SQ_W-1:0];
                    res_next = (res_reg >> 1) + ROOT_RES_W'(bit_reg);
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + STEP_CNT_W'(1);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    span_y_next     = 14'(y_reg) + $signed({2'b00, row_reg});
                    span_color_next = color_reg;
                    span_valid_next = inside_reg;
                    if (inside_reg)
                    begin
                        span_x_next     = 14'(x_reg) + $signed({6'b0, inset});
                        span_width_next = w_reg - {3'b0, inset, 1'b0};
                    end
                    else
                    begin
                        span_x_next     = '0;
                        span_width_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        row_reg        <= row_next;
        color_reg      <= color_next;
        r_reg          <= r_next;
        vy_reg         <= vy_next;
        banded_reg     <= banded_next;
        inside_reg     <= inside_next;
        acc_reg        <= acc_next;
        res_reg        <= res_next;
        bit_reg        <= bit_next;
        cnt_reg        <= cnt_next;
        span_y_reg     <= span_y_next;
        span_x_reg     <= span_x_next;
        span_width_reg <= span_width_next;
        span_valid_reg <= span_valid_next;
        span_color_reg <= span_color_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("sequencer did not leave idle after an item was taken");

    a_root_within_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && banded_reg) |-> (res_reg <= ROOT_RES_W'(r_reg)))
        else $error("square root exceeds the corner radius");

    a_radius_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |->
            (12'(r_reg) <= {1'b0, w_reg[11:1]} && 12'(r_reg) <= {1'b0, h_reg[11:1]}))
        else $error("radius not clamped to half the rectangle");

    a_outside_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !span_valid) |-> (span_x == 14'sd0 && span_width == 12'd0))
        else $error("row outside the rectangle produced a span");

endmodule
